/* design/tcsg_pkg.sv */
// shared types, constants and the cosine/sine table for the turtle segment generator
// no dependencies; every other design file but tcsg_fifo imports this package
`default_nettype none

package tcsg_pkg;

   // fixed field widths of the command and segment channels
   localparam int unsigned POS_W    = 32;
   localparam int unsigned AMOUNT_W = 10;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned COLOUR_W = 2;

   // heading bookkeeping
   localparam int unsigned FULL_TURN     = 360;
   localparam int unsigned QUARTER_TURN  = 90;
   localparam int unsigned HEADING_W     = 9;
   localparam int unsigned HEADING_RESET = 90;
   localparam int unsigned ANGLE_W       = 7;
   localparam int unsigned Q30_FRAC      = 30;
   localparam int unsigned ROM_W         = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FORWARD   = 3'd0,
      ACT_RIGHT     = 3'd1,
      ACT_LEFT      = 3'd2,
      ACT_PEN_UP    = 3'd3,
      ACT_PEN_DOWN  = 3'd4,
      ACT_COLOUR    = 3'd5,
      ACT_ORIGIN    = 3'd6
   } action_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] start_y;
      logic signed [POS_W-1:0] end_x;
      logic signed [POS_W-1:0] end_y;
      logic                    pen_lifted;
      logic [COLOUR_W-1:0]     ink_colour;
   } rsp_type;

   // one move command as it leaves the front part
   typedef struct packed {
      logic                origin;
      logic [1:0]          quadrant;
      logic [ANGLE_W-1:0]  angle_rem;
      logic [AMOUNT_W-1:0] amount;
      logic                pen_lifted;
      logic [COLOUR_W-1:0] ink_colour;
   } move_type;

   typedef logic [QUARTER_TURN-1:0][ROM_W-1:0] rom_type;

   // taylor series for one angle of the first quadrant, q30, clamped at zero
   function automatic logic [ROM_W-1:0] taylor_q30(input int unsigned r, input bit want_cos);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      longint      ss;
      longint      sc;
      longint      v;
      x  = (64'(r) * 64'd3373259426 + 64'd90) / 64'd180;
      x2 = (x * x) >> 30;
      ts = x;
      ss = longint'(x);
      tc = 64'd1 << 30;
      sc = longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd6;    ss = ss - longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd2;    sc = sc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd20;   ss = ss + longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd12;   sc = sc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd42;   ss = ss - longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd30;   sc = sc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd72;   ss = ss + longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd56;   sc = sc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd110;  ss = ss - longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd90;   sc = sc - longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd156;  ss = ss + longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd132;  sc = sc + longint'(tc);
      ts = ((ts * x2) >> 30) / 64'd210;  ss = ss - longint'(ts);
      tc = ((tc * x2) >> 30) / 64'd182;  sc = sc - longint'(tc);
      v = want_cos ? sc : ss;
      if (v < 0) begin
         v = 0;
      end
      return ROM_W'(v);
   endfunction

   function automatic rom_type build_rom(input bit want_cos);
      rom_type rom;
      for (int unsigned r = 0; r < QUARTER_TURN; r++) begin
         rom[r] = taylor_q30(r, want_cos);
      end
      return rom;
   endfunction

   // first-quadrant unit vector in q30, evaluated at elaboration
   localparam rom_type COS_ROM = build_rom(1'b1);
   localparam rom_type SIN_ROM = build_rom(1'b0);

endpackage

`default_nettype wire

/* design/tcsg_fifo.sv */
// small first-in first-out queue held in flip-flops, show-ahead read
// no package dependency; used between the front and back parts and at the output
`default_nettype none

module tcsg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* design/tcsg_front.sv */
// front part: takes commands, keeps heading, pen and colour, forwards moves
// depends on tcsg_pkg
`default_nettype none

module tcsg_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  tcsg_pkg::req_type  req_data,
   output logic               move_push,
   input  logic               move_full,
   output tcsg_pkg::move_type move_data
);

   import tcsg_pkg::*;

   localparam int QUOT_SH = AMOUNT_W + 9;
   localparam int QUOT_W  = AMOUNT_W - 8;
   localparam int PROD_W  = 2 * AMOUNT_W + 1;
   localparam logic [AMOUNT_W:0]    RECIP     = (AMOUNT_W+1)'((64'd1 << QUOT_SH) / FULL_TURN);
   localparam logic [AMOUNT_W-1:0]  TURN_AMT  = AMOUNT_W'(FULL_TURN);
   localparam logic [HEADING_W:0]   TURN_WIDE = (HEADING_W+1)'(FULL_TURN);
   localparam logic [HEADING_W-1:0] Q1_DEG    = HEADING_W'(QUARTER_TURN);
   localparam logic [HEADING_W-1:0] Q2_DEG    = HEADING_W'(2 * QUARTER_TURN);
   localparam logic [HEADING_W-1:0] Q3_DEG    = HEADING_W'(3 * QUARTER_TURN);
   localparam logic [AMOUNT_W-1:0]  MAX_INK   = AMOUNT_W'((1 << COLOUR_W) - 1);

   // input register
   logic                  s0_valid_ff;
   logic [ACTION_W-1:0]   s0_action_ff;
   logic [AMOUNT_W-1:0]   s0_amount_ff;
   logic [HEADING_W-1:0]  s0_turn_ff;

   // turtle state
   logic [HEADING_W-1:0]  heading_ff, heading_in;
   logic                  pen_up_ff, pen_up_in;
   logic [COLOUR_W-1:0]   colour_ff, colour_in;

   logic [PROD_W-1:0]     quot_prod;
   logic [QUOT_W-1:0]     quot_est;
   logic [AMOUNT_W-1:0]   rem_raw;
   logic [HEADING_W-1:0]  turn_mod;
   logic                  is_move;
   logic                  s0_blocked;
   logic                  s0_fire;
   logic [HEADING_W:0]    left_sum;
   logic [HEADING_W:0]    right_sum;
   logic [1:0]            quadrant;
   logic [HEADING_W-1:0]  rem_deg;

   // amount mod 360 by reciprocal multiply, estimate is at most one low
   assign quot_prod = PROD_W'(req_data.amount) * PROD_W'(RECIP);
   assign quot_est  = quot_prod[PROD_W-1:QUOT_SH];
   assign rem_raw   = req_data.amount - AMOUNT_W'(quot_est) * TURN_AMT;
   assign turn_mod  = HEADING_W'((rem_raw >= TURN_AMT) ? rem_raw - TURN_AMT : rem_raw);

   assign is_move    = (s0_action_ff == ACT_FORWARD) || (s0_action_ff == ACT_ORIGIN);
   assign s0_blocked = s0_valid_ff && is_move && move_full;
   assign s0_fire    = s0_valid_ff && !s0_blocked;
   assign req_full   = s0_blocked;

   assign left_sum  = {1'b0, heading_ff} + {1'b0, s0_turn_ff};
   assign right_sum = {1'b0, heading_ff} + TURN_WIDE - {1'b0, s0_turn_ff};

   // heading split into quadrant and angle within it
   always_comb begin
      if (heading_ff >= Q3_DEG) begin
         quadrant = 2'd3;
         rem_deg  = heading_ff - Q3_DEG;
      end else if (heading_ff >= Q2_DEG) begin
         quadrant = 2'd2;
         rem_deg  = heading_ff - Q2_DEG;
      end else if (heading_ff >= Q1_DEG) begin
         quadrant = 2'd1;
         rem_deg  = heading_ff - Q1_DEG;
      end else begin
         quadrant = 2'd0;
         rem_deg  = heading_ff;
      end
   end

   always_comb begin
      heading_in = heading_ff;
      pen_up_in  = pen_up_ff;
      colour_in  = colour_ff;
      unique case (action_type'(s0_action_ff))
         ACT_RIGHT: begin
            heading_in = HEADING_W'((right_sum >= TURN_WIDE) ? right_sum - TURN_WIDE : right_sum);
         end
         ACT_LEFT: begin
            heading_in = HEADING_W'((left_sum >= TURN_WIDE) ? left_sum - TURN_WIDE : left_sum);
         end
         ACT_PEN_UP: begin
            pen_up_in = 1'b1;
         end
         ACT_PEN_DOWN: begin
            pen_up_in = 1'b0;
         end
         ACT_COLOUR: begin
            if (s0_amount_ff <= MAX_INK) begin
               colour_in = COLOUR_W'(s0_amount_ff);
            end
         end
         default: begin
            // moves and the unused code leave this state alone
         end
      endcase
   end

   assign move_push            = s0_valid_ff && is_move && !move_full;
   assign move_data.origin     = (s0_action_ff == ACT_ORIGIN);
   assign move_data.quadrant   = quadrant;
   assign move_data.angle_rem  = ANGLE_W'(rem_deg);
   assign move_data.amount     = s0_amount_ff;
   assign move_data.pen_lifted = pen_up_ff;
   assign move_data.ink_colour = colour_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         heading_ff  <= HEADING_W'(HEADING_RESET);
         pen_up_ff   <= 1'b0;
         colour_ff   <= '0;
      end else begin
         if (!s0_blocked) begin
            s0_valid_ff <= req_push;
         end
         if (s0_fire) begin
            heading_ff <= heading_in;
            pen_up_ff  <= pen_up_in;
            colour_ff  <= colour_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!s0_blocked) begin
         s0_action_ff <= req_data.action;
         s0_amount_ff <= req_data.amount;
         s0_turn_ff   <= turn_mod;
      end
   end

endmodule

`default_nettype wire

/* design/tcsg_back.sv */
// back part: unit vector lookup, scaling by distance, saturating position update
// depends on tcsg_pkg (table and types)
`default_nettype none

module tcsg_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   output logic               move_pop,
   input  logic               move_empty,
   input  tcsg_pkg::move_type move_data,
   output logic               seg_push,
   input  logic               seg_full,
   output tcsg_pkg::rsp_type  seg_data
);

   import tcsg_pkg::*;

   localparam int RND_SH = Q30_FRAC - FRAC_BITS;
   localparam int MAG_W  = FRAC_BITS + 1;
   localparam int UNIT_W = FRAC_BITS + 2;
   localparam int PROD_W = AMOUNT_W + 1 + UNIT_W;
   localparam int SUM_W  = ((POS_W > PROD_W) ? POS_W : PROD_W) + 1;
   localparam logic [ROM_W:0] RND_HALF = (ROM_W+1)'(1) << (RND_SH - 1);

   logic                       adv;

   // stage a: unit vector
   logic                       a_valid_ff;
   logic signed [UNIT_W-1:0]   a_cos_ff;
   logic signed [UNIT_W-1:0]   a_sin_ff;
   logic [AMOUNT_W-1:0]        a_amount_ff;
   logic                       a_origin_ff;
   logic                       a_pen_ff;
   logic [COLOUR_W-1:0]        a_colour_ff;

   // stage b: scaled step
   logic                       b_valid_ff;
   logic signed [PROD_W-1:0]   b_dx_ff;
   logic signed [PROD_W-1:0]   b_dy_ff;
   logic                       b_origin_ff;
   logic                       b_pen_ff;
   logic [COLOUR_W-1:0]        b_colour_ff;

   logic signed [POS_W-1:0]    pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]    pos_y_ff, pos_y_in;

   logic [ROM_W:0]             cos_rnd;
   logic [ROM_W:0]             sin_rnd;
   logic signed [UNIT_W-1:0]   c_pos;
   logic signed [UNIT_W-1:0]   s_pos;
   logic signed [UNIT_W-1:0]   unit_cos;
   logic signed [UNIT_W-1:0]   unit_sin;
   logic signed [PROD_W-1:0]   amount_s;
   logic signed [SUM_W-1:0]    sum_x;
   logic signed [SUM_W-1:0]    sum_y;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){v[SUM_W-1]}});
      if (fits) begin
         return v[POS_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end
      return {1'b0, {(POS_W-1){1'b1}}};
   endfunction

   // the whole back pipe moves together unless the last stage cannot deliver
   assign adv      = !(b_valid_ff && seg_full);
   assign move_pop = adv && !move_empty;

   // round the q30 table value half up
   assign cos_rnd = {1'b0, COS_ROM[move_data.angle_rem]} + RND_HALF;
   assign sin_rnd = {1'b0, SIN_ROM[move_data.angle_rem]} + RND_HALF;
   assign c_pos   = signed'({1'b0, cos_rnd[RND_SH +: MAG_W]});
   assign s_pos   = signed'({1'b0, sin_rnd[RND_SH +: MAG_W]});

   always_comb begin
      unique case (move_data.quadrant)
         2'd0: begin
            unit_cos = c_pos;
            unit_sin = s_pos;
         end
         2'd1: begin
            unit_cos = -s_pos;
            unit_sin = c_pos;
         end
         2'd2: begin
            unit_cos = -c_pos;
            unit_sin = -s_pos;
         end
         default: begin
            unit_cos = s_pos;
            unit_sin = -c_pos;
         end
      endcase
   end

   assign amount_s = PROD_W'(signed'({1'b0, a_amount_ff}));
   assign sum_x    = SUM_W'(pos_x_ff) + SUM_W'(b_dx_ff);
   assign sum_y    = SUM_W'(pos_y_ff) + SUM_W'(b_dy_ff);

   assign seg_push            = b_valid_ff && !seg_full;
   assign seg_data.start_x    = pos_x_ff;
   assign seg_data.start_y    = pos_y_ff;
   assign seg_data.end_x      = pos_x_in;
   assign seg_data.end_y      = pos_y_in;
   assign seg_data.pen_lifted = b_pen_ff;
   assign seg_data.ink_colour = b_colour_ff;

   assign pos_x_in = b_origin_ff ? '0 : signed'(sat_pos(sum_x));
   assign pos_y_in = b_origin_ff ? '0 : signed'(sat_pos(sum_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         if (adv) begin
            a_valid_ff <= move_pop;
            b_valid_ff <= a_valid_ff;
         end
         if (seg_push) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_cos_ff    <= unit_cos;
         a_sin_ff    <= unit_sin;
         a_amount_ff <= move_data.amount;
         a_origin_ff <= move_data.origin;
         a_pen_ff    <= move_data.pen_lifted;
         a_colour_ff <= move_data.ink_colour;
         b_dx_ff     <= amount_s * PROD_W'(a_cos_ff);
         b_dy_ff     <= amount_s * PROD_W'(a_sin_ff);
         b_origin_ff <= a_origin_ff;
         b_pen_ff    <= a_pen_ff;
         b_colour_ff <= a_colour_ff;
      end
   end

endmodule

`default_nettype wire

/* design/turtle_command_segment_generator.sv */
// top level of the turtle command segment generator
// depends on tcsg_pkg, tcsg_fifo, tcsg_front and tcsg_back
`default_nettype none

// Turtle command interpreter. Each command transfer on the req_ side is one of
// forward, turn right, turn left, pen up, pen down, colour or origin; forward
// and origin each produce one segment transfer on the rsp_ side with start and
// end points (two's complement, FRAC_BITS fraction bits), the pen state and the
// ink colour, all other commands produce nothing. The heading starts at 90
// degrees (+y), turns wrap modulo 360 for any amount, positions saturate at the
// signed 32-bit range, colour indexes above 3 are ignored and origin keeps the
// heading. The block takes one command per clock cycle and gives one segment
// per cycle while no queue is full; a segment reaches the rsp_ side through
// the input register and state update, the move queue, the table lookup stage,
// the multiply stage, then the position adder that writes the output queue.
// Both sides behave as queues: a full output queue stalls the back part, a
// full move queue stalls the input, and heading/pen/colour commands never
// stall the input themselves, though they wait behind a move that is held at
// the input register.

module turtle_command_segment_generator #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   // command channel
   input  logic              req_push,
   output logic              req_full,
   input  tcsg_pkg::req_type req_data,
   // segment channel
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output tcsg_pkg::rsp_type rsp_data
);

   import tcsg_pkg::*;

   localparam int MOVE_DEPTH = 4;
   localparam int SEG_DEPTH  = 4;
   localparam int MOVE_W     = $bits(move_type);
   localparam int SEG_W      = $bits(rsp_type);

   // front to move queue
   logic               move_push;
   logic               move_full;
   move_type           move_wr;
   // move queue to back
   logic               move_pop;
   logic               move_empty;
   logic [MOVE_W-1:0]  move_rd_bits;
   move_type           move_rd;
   // back to output queue
   logic               seg_push;
   logic               seg_full;
   rsp_type            seg_wr;
   logic [SEG_W-1:0]   seg_rd_bits;

   // classify commands, keep heading/pen/colour, pass moves on
   tcsg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .move_push (move_push),
      .move_full (move_full),
      .move_data (move_wr)
   );

   // decouples the front from stalls of the position pipe
   tcsg_fifo #(
      .WIDTH (MOVE_W),
      .DEPTH (MOVE_DEPTH)
   ) u_move_q (
      .clock   (clock),
      .reset   (reset),
      .push    (move_push),
      .full    (move_full),
      .wr_data (move_wr),
      .pop     (move_pop),
      .empty   (move_empty),
      .rd_data (move_rd_bits)
   );

   assign move_rd = move_rd_bits;

   // unit vector, scaling and saturating position update
   tcsg_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .move_pop   (move_pop),
      .move_empty (move_empty),
      .move_data  (move_rd),
      .seg_push   (seg_push),
      .seg_full   (seg_full),
      .seg_data   (seg_wr)
   );

   // finished segments wait here for the consumer
   tcsg_fifo #(
      .WIDTH (SEG_W),
      .DEPTH (SEG_DEPTH)
   ) u_seg_q (
      .clock   (clock),
      .reset   (reset),
      .push    (seg_push),
      .full    (seg_full),
      .wr_data (seg_wr),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (seg_rd_bits)
   );

   assign rsp_data = seg_rd_bits;

endmodule

`default_nettype wire

/* design/tcsg_checker.sv */
// port-level checks for turtle_command_segment_generator, bound to the top level
// depends on tcsg_pkg
`default_nettype none

module tcsg_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  tcsg_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  tcsg_pkg::rsp_type rsp_data
);

   import tcsg_pkg::*;

   logic                    rsp_xfer;
   logic signed [POS_W-1:0] last_x_ff;
   logic signed [POS_W-1:0] last_y_ff;

   assign rsp_xfer = rsp_pop && !rsp_empty;

   // end point of the last segment taken, origin after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (rsp_xfer) begin
         last_x_ff <= rsp_data.end_x;
         last_y_ff <= rsp_data.end_y;
      end
   end

   // segments chain: each one starts where the previous one ended
   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_data.start_x == last_x_ff) && (rsp_data.start_y == last_y_ff))
      else $error("segment start does not continue from previous end");

   // reset leaves no segment waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("segment queue not empty after reset");

   // reset leaves the command side open
   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("command side stalled after reset");

   // a waiting segment stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting segment changed before transfer");

endmodule

bind turtle_command_segment_generator tcsg_checker u_tcsg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/sv/turtle_segment_checker.sv */
// segment checker for the turtle command segment generator: tracks the turtle
// state from accepted commands and compares every popped segment against it
// depends on tcsg_pkg for the channel payload types and the action codes
`default_nettype none

module turtle_segment_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  tcsg_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  tcsg_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_segments
);

   import tcsg_pkg::*;

   localparam int FRAC = 16;
   localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 1;
   localparam longint POS_MIN = -POS_MAX - 1;

   // turtle state as the block should hold it
   int unsigned heading;
   longint      turtle_x;
   longint      turtle_y;
   logic        pen_up;
   logic [1:0]  colour;

   rsp_type segments_due_q[$];

   // round a q30 value to FRAC fraction bits, negatives clamp to zero
   function automatic longint q30_round(input longint v);
      if (v < 0) begin
         v = 0;
      end
      return (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
   endfunction

   // cos and sin of a whole-degree heading from a truncated taylor series
   function automatic void heading_vector(input int unsigned deg,
                                          output longint cv, output longint sv);
      int unsigned quad;
      int unsigned rem;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      longint      ss;
      longint      sc;
      longint      s;
      longint      c;
      quad = (deg % FULL_TURN) / QUARTER_TURN;
      rem  = (deg % FULL_TURN) % QUARTER_TURN;
      x  = (64'(rem) * 64'd3373259426 + 64'd90) / 64'd180;
      x2 = (x * x) >> 30;
      ts = x;
      ss = longint'(x);
      tc = 64'd1 << 30;
      sc = longint'(tc);
      for (int k = 1; k <= 7; k++) begin
         ts = ((ts * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
         tc = ((tc * x2) >> 30) / (64'(2 * k - 1) * 64'(2 * k));
         if (k % 2 == 1) begin
            ss = ss - longint'(ts);
            sc = sc - longint'(tc);
         end else begin
            ss = ss + longint'(ts);
            sc = sc + longint'(tc);
         end
      end
      s = q30_round(ss);
      c = q30_round(sc);
      case (quad)
         0: begin
            cv = c;  sv = s;
         end
         1: begin
            cv = -s; sv = c;
         end
         2: begin
            cv = -c; sv = -s;
         end
         default: begin
            cv = s;  sv = -c;
         end
      endcase
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > POS_MAX) begin
         return POS_MAX;
      end
      if (v < POS_MIN) begin
         return POS_MIN;
      end
      return v;
   endfunction

   // apply one command to the tracked state, queue the segment it makes
   task automatic interpret_command(input req_type cmd);
      rsp_type     seg;
      longint      cv;
      longint      sv;
      longint      nx;
      longint      ny;
      int unsigned turn;
      turn = int'(cmd.amount) % FULL_TURN;
      seg.start_x    = 32'(turtle_x);
      seg.start_y    = 32'(turtle_y);
      seg.pen_lifted = pen_up;
      seg.ink_colour = colour;
      case (cmd.action)
         ACT_FORWARD: begin
            heading_vector(heading, cv, sv);
            nx = clamp_pos(turtle_x + longint'(cmd.amount) * cv);
            ny = clamp_pos(turtle_y + longint'(cmd.amount) * sv);
            seg.end_x = 32'(nx);
            seg.end_y = 32'(ny);
            segments_due_q = {segments_due_q, seg};
            turtle_x = nx;
            turtle_y = ny;
         end
         ACT_RIGHT:    heading = (heading + FULL_TURN - turn) % FULL_TURN;
         ACT_LEFT:     heading = (heading + turn) % FULL_TURN;
         ACT_PEN_UP:   pen_up = 1'b1;
         ACT_PEN_DOWN: pen_up = 1'b0;
         ACT_COLOUR: begin
            if (cmd.amount <= 3) begin
               colour = cmd.amount[1:0];
            end
         end
         ACT_ORIGIN: begin
            seg.end_x = '0;
            seg.end_y = '0;
            segments_due_q = {segments_due_q, seg};
            turtle_x = 0;
            turtle_y = 0;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         heading  = HEADING_RESET;
         turtle_x = 0;
         turtle_y = 0;
         pen_up   = 1'b0;
         colour   = '0;
         segments_due_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (segments_due_q.size() == 0) begin
               $error("segment transfer with nothing expected: %h", rsp_data);
               fail_count++;
            end else begin
               want = segments_due_q.pop_front();
               check_field("start_x", want.start_x, rsp_data.start_x);
               check_field("start_y", want.start_y, rsp_data.start_y);
               check_field("end_x", want.end_x, rsp_data.end_x);
               check_field("end_y", want.end_y, rsp_data.end_y);
               check_field("pen_lifted", 32'(want.pen_lifted), 32'(rsp_data.pen_lifted));
               check_field("ink_colour", 32'(want.ink_colour), 32'(rsp_data.ink_colour));
            end
         end
         if (req_push && !req_full) begin
            interpret_command(req_data);
         end
      end
      pending_segments = segments_due_q.size();
   end

endmodule

`default_nettype wire

/* tb/sv/turtle_command_segment_generator_test.sv */
// top of the turtle command segment generator testbench: clock, reset,
// command stimulus with random gaps, segment pops with random stalls, verdict
// depends on tcsg_pkg, turtle_segment_checker and the design
`default_nettype none

module turtle_command_segment_generator_test;
   import tcsg_pkg::*;

   // the one code the action enum leaves out; the block must ignore it
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam int unsigned AMOUNT_MAX = (1 << AMOUNT_W) - 1;
   localparam int RANDOM_ITEMS = 750;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   int fail_count;
   int pending_segments;

   // when set, neither side inserts gaps or stalls
   bit no_idle;

   turtle_command_segment_generator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   turtle_segment_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .fail_count       (fail_count),
      .pending_segments (pending_segments)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   function automatic req_type make_cmd(input logic [ACTION_W-1:0] act,
                                        input int unsigned amt);
      req_type c;
      c.action = act;
      c.amount = AMOUNT_W'(amt);
      return c;
   endfunction

   // one command transfer; called right after a falling edge and returns
   // right after the falling edge that follows the transfer
   task automatic send_command(input req_type cmd);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_full !== 1'b0);
      @(negedge clock);
   endtask

   // a single command drawn over all actions, forward the most likely
   function automatic req_type random_command();
      int unsigned pick;
      int unsigned amt;
      pick = $urandom_range(0, 99);
      amt  = $urandom_range(0, AMOUNT_MAX);
      if (pick < 35) begin
         // distance extremes now and then
         if ($urandom_range(0, 9) == 0) begin
            amt = $urandom_range(0, 1) ? AMOUNT_MAX : 0;
         end
         return make_cmd(ACT_FORWARD, amt);
      end else if (pick < 47) begin
         return make_cmd(ACT_RIGHT, amt);
      end else if (pick < 59) begin
         return make_cmd(ACT_LEFT, amt);
      end else if (pick < 67) begin
         return make_cmd(ACT_PEN_UP, amt);
      end else if (pick < 75) begin
         return make_cmd(ACT_PEN_DOWN, amt);
      end else if (pick < 87) begin
         // half valid colour indexes, half anything
         if ($urandom_range(0, 1)) begin
            amt = $urandom_range(0, 3);
         end
         return make_cmd(ACT_COLOUR, amt);
      end else if (pick < 95) begin
         return make_cmd(ACT_ORIGIN, amt);
      end
      return make_cmd(ACT_UNUSED, amt);
   endfunction

   // segment side: a random stall before each transfer, then pop held high
   initial begin
      int stall;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         @(negedge clock);
      end
   end

   initial begin
      int random_sent;
      int run_len;
      int drain_cycles;
      req_type cmd;
      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      no_idle  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: first forward follows the reset heading of +y
      send_command(make_cmd(ACT_FORWARD, 0));
      send_command(make_cmd(ACT_FORWARD, AMOUNT_MAX));
      // quarter right to +x, full distance
      send_command(make_cmd(ACT_RIGHT, 90));
      send_command(make_cmd(ACT_FORWARD, AMOUNT_MAX));
      // turns past a full circle wrap
      send_command(make_cmd(ACT_LEFT, AMOUNT_MAX));
      send_command(make_cmd(ACT_FORWARD, 5));
      send_command(make_cmd(ACT_RIGHT, 0));
      send_command(make_cmd(ACT_LEFT, 360));
      send_command(make_cmd(ACT_RIGHT, 359));
      send_command(make_cmd(ACT_RIGHT, AMOUNT_MAX));
      send_command(make_cmd(ACT_LEFT, 1));
      send_command(make_cmd(ACT_FORWARD, 7));
      // pen lifted segment, then origin with pen up and down
      send_command(make_cmd(ACT_PEN_UP, 0));
      send_command(make_cmd(ACT_FORWARD, 3));
      send_command(make_cmd(ACT_ORIGIN, AMOUNT_MAX));
      send_command(make_cmd(ACT_PEN_DOWN, AMOUNT_MAX));
      send_command(make_cmd(ACT_ORIGIN, 0));
      // colour indexes above 3 leave the colour alone
      send_command(make_cmd(ACT_COLOUR, 3));
      send_command(make_cmd(ACT_COLOUR, 4));
      send_command(make_cmd(ACT_COLOUR, AMOUNT_MAX));
      send_command(make_cmd(ACT_FORWARD, 1));
      send_command(make_cmd(ACT_COLOUR, 2));
      send_command(make_cmd(ACT_UNUSED, AMOUNT_MAX));
      send_command(make_cmd(ACT_FORWARD, 2));
      send_command(make_cmd(ACT_COLOUR, 0));

      // random: mostly single commands, with long straight runs at full
      // stride that drive the position into saturation at random headings
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            no_idle = ~no_idle;
         end
         if ($urandom_range(0, 99) < 2) begin
            send_command(make_cmd(ACT_LEFT, $urandom_range(0, AMOUNT_MAX)));
            run_len = $urandom_range(30, 48);
            repeat (run_len) begin
               send_command(make_cmd(ACT_FORWARD, $urandom_range(800, AMOUNT_MAX)));
            end
            random_sent += run_len + 1;
         end else begin
            cmd = random_command();
            send_command(cmd);
            if (cmd.action != ACT_UNUSED) begin
               random_sent++;
            end
         end
      end
      req_push <= 1'b0;
      no_idle = 1'b0;

      // drain the segment side, then give the pipeline time to show strays
      drain_cycles = 0;
      while (pending_segments != 0 && drain_cycles < 5000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (20) @(negedge clock);
      if (pending_segments != 0) begin
         $error("%0d expected segments never arrived", pending_segments);
      end
      if (fail_count == 0 && pending_segments == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
